[hdl/lzd_pkg.sv]
// Shared types and constants for the LZ77 triple decoder.
`default_nettype none
package lzd_pkg;
	localparam int WINDOW_DEPTH_DEF = 256;
	localparam int BYTES_PER_RESULT_DEF = 8;
	localparam int BYTE_SLOTS = 8;
	localparam int MIN_COPY = 2;

	// one decoded byte or end-of-item marker from sequencer to packer
	typedef struct packed {
		logic       put;
		logic [7:0] data;
		logic       fin;
	} lzd_byte_t;
endpackage
`default_nettype wire

[hdl/lzd_ram.sv]
// Generic single-port-write, registered-read RAM.
`default_nettype none
module lzd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

[hdl/lzd_pack.sv]
// Output packer: groups decoded bytes into results and holds the output register.
`default_nettype none
module lzd_pack import lzd_pkg::*; #(
	parameter int BYTES_PER_RESULT = BYTES_PER_RESULT_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire lzd_byte_t  bin,
	output logic            go,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_bytes [BYTE_SLOTS],
	output logic [3:0]      byte_count,
	output logic            last_of_item
);
	localparam int CHUNK = (BYTES_PER_RESULT > BYTE_SLOTS) ? BYTE_SLOTS :
		((BYTES_PER_RESULT < 1) ? 1 : BYTES_PER_RESULT);

	logic [7:0] buf_q [CHUNK];
	logic [3:0] cnt_q;
	logic       valid_q;
	logic [7:0] ob_q [BYTE_SLOTS];
	logic [3:0] bc_q;
	logic       last_q;

	assign go = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_bytes = ob_q;
	assign byte_count = bc_q;
	assign last_of_item = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (valid_q && !out_stall) begin
				valid_q <= 1'b0;
			end
			if (go && (bin.put || bin.fin)) begin
				// full chunk waits for the next kept byte or the end marker
				if (bin.fin || cnt_q == 4'(CHUNK)) begin
					valid_q <= 1'b1;
					bc_q    <= cnt_q;
					last_q  <= bin.fin;
					for (int k = 0; k < BYTE_SLOTS; k++) begin
						ob_q[k] <= 8'd0;
						if (k < CHUNK) begin
							if (4'(k) < cnt_q) begin
								ob_q[k] <= buf_q[k];
							end
						end
					end
				end
				if (bin.fin) begin
					cnt_q <= '0;
				end else if (cnt_q == 4'(CHUNK)) begin
					buf_q[0] <= bin.data;
					cnt_q    <= 4'd1;
				end else begin
					for (int k = 0; k < CHUNK; k++) begin
						if (4'(k) == cnt_q) begin
							buf_q[k] <= bin.data;
						end
					end
					cnt_q <= cnt_q + 4'd1;
				end
			end
		end
	end
endmodule
`default_nettype wire

[hdl/lzd_seq.sv]
// Triple sequencer: reads the history ring, writes decoded bytes back, tracks position.
`default_nettype none
module lzd_seq import lzd_pkg::*; #(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  distance,
	input  wire logic [7:0]  match_length,
	input  wire logic [7:0]  next_value,
	input  wire logic [31:0] olen,
	input  wire logic        go,
	output lzd_byte_t        bout,
	output logic             ram_we,
	output logic [$clog2(WINDOW_DEPTH)-1:0] ram_waddr,
	output logic [7:0]       ram_wdata,
	output logic             ram_re,
	output logic [$clog2(WINDOW_DEPTH)-1:0] ram_raddr,
	input  wire logic [7:0]  ram_rdata
);
	localparam int AW = $clog2(WINDOW_DEPTH);

	typedef enum logic [2:0] {S_IDLE, S_LIT1, S_LIT2, S_COPY, S_VAL, S_FIN} state_t;

	state_t            state_q;
	logic [7:0]        dist_q, len_q, val_q;
	logic [8:0]        rem_q;
	logic [31:0]       pos_q;
	logic [AW-1:0]     rd_pos_q;
	logic [WINDOW_DEPTH-1:0] vld_q;
	logic              v_s1, fwd_s1, vld_s1;
	logic [7:0]        fwd_data_s1;
	logic [AW-1:0]     idx_s1;
	logic [7:0]        cp_byte;
	logic              issue;

	assign in_stall = (state_q != S_IDLE);
	assign cp_byte = fwd_s1 ? fwd_data_s1 : (vld_s1 ? ram_rdata : 8'(idx_s1));
	assign ram_waddr = pos_q[AW-1:0];
	assign ram_raddr = rd_pos_q - dist_q[AW-1:0];
	assign ram_re = issue;

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = val_q;
		issue     = 1'b0;
		if (go) begin
			unique case (state_q)
				S_LIT1: ram_we = 1'b1;
				S_LIT2: begin
					ram_we    = 1'b1;
					ram_wdata = len_q;
				end
				S_COPY: begin
					ram_we    = v_s1;
					ram_wdata = cp_byte;
					issue     = (rem_q != 9'd0);
				end
				S_VAL: ram_we = 1'b1;
				default: ;
			endcase
		end
		bout.put  = ram_we && (pos_q < olen);
		bout.data = ram_wdata;
		bout.fin  = go && (state_q == S_FIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pos_q   <= '0;
			vld_q   <= '0;
			v_s1    <= 1'b0;
			rem_q   <= '0;
		end else begin
			if (state_q == S_IDLE) begin
				if (in_valid) begin
					dist_q   <= distance;
					len_q    <= match_length;
					val_q    <= next_value;
					rem_q    <= {1'b0, match_length} + 9'(MIN_COPY);
					rd_pos_q <= pos_q[AW-1:0];
					state_q  <= (distance == 8'd0) ? S_LIT1 : S_COPY;
				end
			end else if (go) begin
				if (ram_we) begin
					pos_q <= pos_q + 32'd1;
					vld_q[ram_waddr] <= 1'b1;
				end
				v_s1 <= issue;
				if (issue) begin
					rd_pos_q    <= rd_pos_q + 1'b1;
					rem_q       <= rem_q - 9'd1;
					fwd_s1      <= ram_we && (ram_waddr == ram_raddr);
					fwd_data_s1 <= ram_wdata;
					vld_s1      <= vld_q[ram_raddr];
					idx_s1      <= ram_raddr;
				end
				unique case (state_q)
					S_LIT1: state_q <= S_LIT2;
					S_LIT2: state_q <= S_FIN;
					S_COPY: if (rem_q == 9'd0) state_q <= S_VAL;
					S_VAL:  state_q <= S_FIN;
					S_FIN:  state_q <= S_IDLE;
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end
endmodule
`default_nettype wire

[hdl/lz77_triple_decoder_unit.sv]
// Top level of the LZ77 triple decoder: sequencer, history RAM and output packer.
// A full result is sent when the ninth kept byte of an item or the end of the item arrives.
// Matches are copied one byte per cycle, while the output register is not held,
// through the read/write loop on the history RAM.
// A stalled output result freezes the whole engine; a new request is taken as soon as the engine is idle.
// Reset: position and output length clear; history entries read as their own index
// until written (per-entry valid bits, no clearing pass).
`default_nettype none
module lz77_triple_decoder_unit import lzd_pkg::*; #(
	parameter int WINDOW_DEPTH     = WINDOW_DEPTH_DEF,
	parameter int BYTES_PER_RESULT = BYTES_PER_RESULT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  distance,
	input  wire logic [7:0]  match_length,
	input  wire logic [7:0]  next_value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte0,
	output logic [7:0]       out_byte1,
	output logic [7:0]       out_byte2,
	output logic [7:0]       out_byte3,
	output logic [7:0]       out_byte4,
	output logic [7:0]       out_byte5,
	output logic [7:0]       out_byte6,
	output logic [7:0]       out_byte7,
	output logic [3:0]       byte_count,
	output logic             last_of_item
);
	localparam int AW = $clog2(WINDOW_DEPTH);

	logic [31:0]   olen_q;
	logic          go;
	lzd_byte_t     bstream;
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_wdata, ram_rdata;
	logic [7:0]    ob [BYTE_SLOTS];

	// output length register; the user must write it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			olen_q <= '0;
		end else if (cfg_we) begin
			olen_q <= cfg_wdata;
		end
	end

	// history ring
	lzd_ram #(.WIDTH(8), .DEPTH(WINDOW_DEPTH)) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// per-request byte sequencer, with write-to-read forwarding for distance one
	lzd_seq #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.distance     (distance),
		.match_length (match_length),
		.next_value   (next_value),
		.olen         (olen_q),
		.go           (go),
		.bout         (bstream),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata)
	);

	// packing into results; go drops when the output register is held
	lzd_pack #(.BYTES_PER_RESULT(BYTES_PER_RESULT)) u_pack (
		.clk          (clk),
		.arst_n       (arst_n),
		.bin          (bstream),
		.go           (go),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_bytes    (ob),
		.byte_count   (byte_count),
		.last_of_item (last_of_item)
	);

	assign out_byte0 = ob[0];
	assign out_byte1 = ob[1];
	assign out_byte2 = ob[2];
	assign out_byte3 = ob[3];
	assign out_byte4 = ob[4];
	assign out_byte5 = ob[5];
	assign out_byte6 = ob[6];
	assign out_byte7 = ob[7];
endmodule
`default_nettype wire

[verif/tb_lz77_triple_decoder_unit.sv]
// Self-checking testbench for the LZ77 triple decoder unit.
`default_nettype none
module tb_lz77_triple_decoder_unit;
	import lzd_pkg::*;

	// decoded-stream result as seen on the output port
	typedef struct packed {
		logic [7:0][7:0] bytes;   // bytes[k] is out_byte<k>
		logic [3:0]      count;
		logic            last;
	} chunk_t;

	localparam int  RING = 256;
	localparam int  PACK = BYTES_PER_RESULT_DEF;
	localparam int  TIMEOUT_CYCLES = 2_000_000;
	localparam int  DRAIN_CYCLES = 300;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  distance;
	logic [7:0]  match_length;
	logic [7:0]  next_value;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_byte0, out_byte1, out_byte2, out_byte3;
	logic [7:0]  out_byte4, out_byte5, out_byte6, out_byte7;
	logic [3:0]  byte_count;
	logic        last_of_item;

	lz77_triple_decoder_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.distance     (distance),
		.match_length (match_length),
		.next_value   (next_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte0    (out_byte0),
		.out_byte1    (out_byte1),
		.out_byte2    (out_byte2),
		.out_byte3    (out_byte3),
		.out_byte4    (out_byte4),
		.out_byte5    (out_byte5),
		.out_byte6    (out_byte6),
		.out_byte7    (out_byte7),
		.byte_count   (byte_count),
		.last_of_item (last_of_item)
	);

	// Predictor state: its own copy of the history window, stream position
	// and emit limit.
	logic [7:0]  hist_ring [RING];
	logic [31:0] stream_pos;
	logic [31:0] emit_limit;

	chunk_t      pending_chunks [$];
	int          mismatch_cnt;
	int          stray_cnt;
	longint      cycle_cnt;
	bit          stall_mode;   // receiver pattern selector

	// ------------------------------------------------------------------
	// Clock, cycle counter and watchdog
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycle_cnt = 0;
		forever begin
			@(posedge clk);
			cycle_cnt++;
			if (cycle_cnt > TIMEOUT_CYCLES) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Predictor: decode one triple into the expected result queue.
	// ------------------------------------------------------------------
	function automatic void put_decoded(input logic [7:0] b, inout logic [7:0] buf_q [$]);
		// bytes past the limit still go to the window, just not out
		if (stream_pos < emit_limit) buf_q.push_back(b);
		hist_ring[stream_pos[7:0]] = b;
		stream_pos = stream_pos + 32'd1;
	endfunction

	function automatic void decode_triple(input logic [7:0] back, input logic [7:0] len,
			input logic [7:0] val);
		logic [7:0] buf_q [$];
		chunk_t     c;
		int         pos;
		int         cnt;
		logic [7:0] src;
		if (back == 8'd0) begin
			put_decoded(val, buf_q);
			put_decoded(len, buf_q);
		end else begin
			// byte at a time, so overlapping copies replicate the pattern
			for (int k = 0; k < int'(len) + MIN_COPY; k++) begin
				src = stream_pos[7:0] - back;
				put_decoded(hist_ring[src], buf_q);
			end
			put_decoded(val, buf_q);
		end
		if (buf_q.size() == 0) begin
			// everything dropped: one empty marker result
			c = '0;
			c.last = 1'b1;
			pending_chunks.push_back(c);
			return;
		end
		for (pos = 0; pos < buf_q.size(); pos += PACK) begin
			cnt = buf_q.size() - pos;
			if (cnt > PACK) cnt = PACK;
			c = '0;
			for (int k = 0; k < cnt; k++) c.bytes[k] = buf_q[pos + k];
			c.count = cnt[3:0];
			c.last = (pos + cnt >= buf_q.size());
			pending_chunks.push_back(c);
		end
	endfunction

	// ------------------------------------------------------------------
	// Result checker and receiver stall pattern
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		chunk_t got;
		chunk_t want;
		if (arst_n && out_valid && !out_stall) begin
			got.bytes = {out_byte7, out_byte6, out_byte5, out_byte4,
				out_byte3, out_byte2, out_byte1, out_byte0};
			got.count = byte_count;
			got.last  = last_of_item;
			if (pending_chunks.size() == 0) begin
				stray_cnt++;
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("unexpected result: bytes=%h count=%0d last=%0b",
						got.bytes, got.count, got.last);
			end else begin
				want = pending_chunks.pop_front();
				if (got !== want) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("mismatch: exp bytes=%h count=%0d last=%0b | got bytes=%h count=%0d last=%0b",
							want.bytes, want.count, want.last,
							got.bytes, got.count, got.last);
				end
			end
		end
	end

	// Receiver: alternates between a stall-free mode and a random mode,
	// switching now and then so stalls hit every phase of the engine.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if ($urandom_range(0, 199) == 0) stall_mode = ~stall_mode;
			out_stall <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------
	int burst_left;

	// One request: wait out a random gap when the burst is spent, then
	// hold the triple until accepted.
	task automatic send_triple(input logic [7:0] back, input logic [7:0] len,
			input logic [7:0] val);
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(10, 30)
				: $urandom_range(1, 5);
		end
		burst_left--;
		in_valid     <= 1'b1;
		distance     <= back;
		match_length <= len;
		next_value   <= val;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		decode_triple(back, len, val);
		@(negedge clk);
		// leave valid high; next call or the idle task lowers it
	endtask

	task automatic go_idle();
		in_valid <= 1'b0;
	endtask

	// Wait for every outstanding result, then the engine's own tail.
	task automatic drain();
		go_idle();
		while (pending_chunks.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(input logic [31:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		emit_limit = value;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Limit still zero after reset: every triple yields the empty marker.
	task automatic test_reset_limit();
		send_triple(8'd0, 8'hFF, 8'h00);
		send_triple(8'd3, 8'd0, 8'hAA);
		drain();
	endtask

	// Field extremes, literal pairs, overlap and reads before the start.
	task automatic test_directed();
		write_limit(32'hFFFF_FFFF);
		send_triple(8'd1, 8'd0, 8'h11);       // distance one: repeats the last byte written
		send_triple(8'd255, 8'd255, 8'hFF);   // longest match, farthest back
		send_triple(8'd0, 8'h00, 8'hFF);      // literal pair
		send_triple(8'd0, 8'hFF, 8'h00);
		send_triple(8'd0, 8'h55, 8'hAA);
		send_triple(8'd1, 8'd20, 8'h01);      // overlap: run of one byte
		send_triple(8'd3, 8'd13, 8'h80);      // overlap: period three
		send_triple(8'd128, 8'd6, 8'h7F);
		send_triple(8'd2, 8'd5, 8'h42);       // exactly one full result
		send_triple(8'd8, 8'd0, 8'h24);
		drain();
	endtask

	// Limit falling inside a triple, then exhausted.
	task automatic test_limit_edges();
		write_limit(stream_pos + 32'd5);
		send_triple(8'd4, 8'd10, 8'h33);      // cut after five bytes
		send_triple(8'd0, 8'h12, 8'h34);      // fully dropped
		drain();
		write_limit(stream_pos + 32'd1);
		send_triple(8'd0, 8'h56, 8'h78);      // only first literal kept
		drain();
		write_limit(32'd0);
		send_triple(8'd7, 8'd3, 8'h9C);
		drain();
	endtask

	// Random triples, mostly matches with short lengths, some long ones.
	task automatic test_random(input int n_items);
		logic [7:0] d, l, v;
		for (int i = 0; i < n_items; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: d = 8'd0;
				3, 4:    d = 8'($urandom_range(1, 8));
				default: d = 8'($urandom_range(1, 255));
			endcase
			l = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(0, 12));
			if (d == 8'd0) l = 8'($urandom_range(0, 255));
			v = 8'($urandom_range(0, 255));
			send_triple(d, l, v);
			// sender pause until all results are back
			if (i == n_items / 2) begin
				go_idle();
				while (pending_chunks.size() != 0) @(negedge clk);
			end
		end
		drain();
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		in_valid     = 1'b0;
		distance     = '0;
		match_length = '0;
		next_value   = '0;
		out_stall    = 1'b0;
		stall_mode   = 1'b0;
		mismatch_cnt = 0;
		stray_cnt    = 0;
		burst_left   = 0;
		for (int i = 0; i < RING; i++) hist_ring[i] = i[7:0];
		stream_pos = '0;
		emit_limit = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_limit();
		test_directed();
		test_limit_edges();
		write_limit(32'hFFFF_FFFF);
		test_random(200);
		// limit part way through the random stream
		write_limit(stream_pos + 32'd600);
		stall_mode = 1'b1;
		test_random(200);

		if (mismatch_cnt == 0 && pending_chunks.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
`default_nettype wire
